@@ src/ook46_pkg.sv @@
// Shared types, constants and helper functions for the OOK 4b6b frame transmitter.
// No dependencies; every other source file imports this package.
`default_nettype none

package ook46_pkg;

   // Sizing
   localparam int MAX_PAYLOAD      = 27;
   localparam int TICKS_PER_BIT    = 8;
   localparam int PREAMBLE_SYMBOLS = 8;

   localparam int COUNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int ADDR_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int SYM_W   = $clog2(PREAMBLE_SYMBOLS + 2 * MAX_PAYLOAD + 7);
   localparam int PHASE_W = (TICKS_PER_BIT > 1) ? $clog2(TICKS_PER_BIT) : 1;

   localparam logic [15:0] CRC_SEED = 16'hffff;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_SEND   = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NOP    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BUSY     = 2'd1,
      ST_TOO_LONG = 2'd2
   } status_type;

   // Payload buffer write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } buf_wr_type;

   // One result item as produced by the engine
   typedef struct packed {
      logic        tx_line;
      logic        tx_active;
      status_type  status;
      logic        message_done;
      logic [15:0] messages_sent;
   } result_type;

   // Balanced 6-bit code for each nibble
   function automatic logic [5:0] code_of(input logic [3:0] nib);
      logic [5:0] code;
      unique case (nib)
         4'h0: code = 6'h0d;
         4'h1: code = 6'h0e;
         4'h2: code = 6'h13;
         4'h3: code = 6'h15;
         4'h4: code = 6'h16;
         4'h5: code = 6'h19;
         4'h6: code = 6'h1a;
         4'h7: code = 6'h1c;
         4'h8: code = 6'h23;
         4'h9: code = 6'h25;
         4'ha: code = 6'h26;
         4'hb: code = 6'h29;
         4'hc: code = 6'h2a;
         4'hd: code = 6'h2c;
         4'he: code = 6'h32;
         default: code = 6'h34;
      endcase
      return code;
   endfunction

   // Preamble symbol by position: six 0x2a, then 0x38, 0x2c
   function automatic logic [5:0] preamble_of(input logic [2:0] pos);
      logic [5:0] sym;
      unique case (pos)
         3'd6:    sym = 6'h38;
         3'd7:    sym = 6'h2c;
         default: sym = 6'h2a;
      endcase
      return sym;
   endfunction

   // Reflected CRC-16 CCITT, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/ook46_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on ook46_pkg for field types.
`default_nettype none

interface ook46_req_if
   import ook46_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface ook46_rsp_if
   import ook46_pkg::*;
();
   logic        valid;
   logic        ready;
   logic        tx_line;
   logic        tx_active;
   logic [1:0]  status;
   logic        message_done;
   logic [15:0] messages_sent;

   modport source (output valid, output tx_line, output tx_active, output status,
                   output message_done, output messages_sent, input ready);
   modport sink   (input valid, input tx_line, input tx_active, input status,
                   input message_done, input messages_sent, output ready);
endinterface

`default_nettype wire

@@ src/ook46_payload_buf.sv @@
// Payload byte store: one write port, one registered read port.
// Depends on ook46_pkg.
`default_nettype none

module ook46_payload_buf
   import ook46_pkg::*;
(
   input  wire logic              clock,
   input  wire buf_wr_type        wr,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] store_ff [MAX_PAYLOAD];
   logic [7:0] rd_data_ff;

   // Write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   // Registered read; addresses past the end give zero
   always_ff @(posedge clock) begin
      if (32'(rd_addr) < MAX_PAYLOAD) begin
         rd_data_ff <= store_ff[rd_addr];
      end else begin
         rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/ook46_tx_engine.sv @@
// Command decode, frame sequencer, 4b6b encoder and running CRC.
// Depends on ook46_pkg and ook46_payload_buf.
`default_nettype none

module ook46_tx_engine
   import ook46_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [1:0] command,
   input  wire logic [7:0] data_byte,
   output result_type      result
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic [15:0]        crc_ff, crc_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [2:0]         bit_ff, bit_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               active_ff, active_in;
   logic               line_ff, line_in;
   logic [15:0]        counter_ff, counter_in;

   buf_wr_type         wr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data;

   logic [SYM_W-1:0]   data_pos;
   logic [SYM_W-1:0]   next_data_pos;
   logic [SYM_W-2:0]   byte_idx;
   logic               in_preamble;
   logic               in_data;
   logic [7:0]         cur_byte;
   logic [3:0]         nibble;
   logic [15:0]        fcs;
   logic [1:0]         fcs_sel;
   logic [5:0]         symbol;
   logic [SYM_W-1:0]   frame_len;
   status_type         status;
   logic               done;
   command_type        cmd;

   ook46_payload_buf u_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Symbol at the current frame position
   always_comb begin
      in_preamble = 32'(sym_ff) < PREAMBLE_SYMBOLS;
      data_pos    = sym_ff - SYM_W'(PREAMBLE_SYMBOLS);
      byte_idx    = data_pos[SYM_W-1:1];
      in_data     = 32'(byte_idx) <= 32'(count_ff);
      cur_byte    = (byte_idx == '0) ? (8'(count_ff) + 8'd3) : rd_data;
      fcs         = ~crc_ff;
      fcs_sel     = 2'(data_pos - SYM_W'(2) - SYM_W'({count_ff, 1'b0}));
      frame_len   = SYM_W'(PREAMBLE_SYMBOLS + 6) + SYM_W'({count_ff, 1'b0});
      if (in_data) begin
         nibble = data_pos[0] ? cur_byte[3:0] : cur_byte[7:4];
      end else begin
         unique case (fcs_sel)
            2'd0:    nibble = fcs[7:4];
            2'd1:    nibble = fcs[3:0];
            2'd2:    nibble = fcs[15:12];
            default: nibble = fcs[11:8];
         endcase
      end
      symbol = in_preamble ? preamble_of(sym_ff[2:0]) : code_of(nibble);
   end

   // Command handling and next state
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      crc_in      = crc_ff;
      sym_in      = sym_ff;
      bit_in      = bit_ff;
      phase_in    = phase_ff;
      active_in   = active_ff;
      line_in     = line_ff;
      counter_in  = counter_ff;
      status      = ST_OK;
      done        = 1'b0;
      cmd         = command_type'(command);
      wr.en       = 1'b0;
      wr.addr     = count_ff[ADDR_W-1:0];
      wr.data     = data_byte;

      if (accept) begin
         unique case (cmd)
            CMD_APPEND: begin
               if (active_ff) begin
                  status = ST_BUSY;
               end else if (overflow_ff || 32'(count_ff) >= MAX_PAYLOAD) begin
                  overflow_in = 1'b1;
                  status      = ST_TOO_LONG;
               end else begin
                  wr.en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_SEND: begin
               if (active_ff) begin
                  status = ST_BUSY;
               end else if (overflow_ff) begin
                  overflow_in = 1'b0;
                  count_in    = '0;
                  status      = ST_TOO_LONG;
               end else begin
                  crc_in    = CRC_SEED;
                  sym_in    = '0;
                  bit_in    = '0;
                  phase_in  = '0;
                  line_in   = 1'b1;
                  active_in = 1'b1;
               end
            end
            CMD_TICK: begin
               if (active_ff) begin
                  if (phase_ff == '0) begin
                     if (sym_ff >= frame_len) begin
                        // end of frame, one bit period after the last bit
                        line_in    = 1'b0;
                        active_in  = 1'b0;
                        counter_in = counter_ff + 16'd1;
                        count_in   = '0;
                        done       = 1'b1;
                     end else begin
                        line_in = symbol[bit_ff];
                        // fold each count/payload byte into the CRC as it starts
                        if (!in_preamble && in_data && !data_pos[0] && bit_ff == '0) begin
                           crc_in = crc_byte(crc_ff, cur_byte);
                        end
                        if (bit_ff == 3'd5) begin
                           bit_in = '0;
                           sym_in = sym_ff + 1'b1;
                        end else begin
                           bit_in = bit_ff + 3'd1;
                        end
                     end
                  end
                  if (32'(phase_ff) == TICKS_PER_BIT - 1) begin
                     phase_in = '0;
                  end else begin
                     phase_in = phase_ff + 1'b1;
                  end
               end
            end
            default: begin
               // no operation
            end
         endcase
      end

      result.tx_line       = line_in;
      result.tx_active     = active_in;
      result.status        = status;
      result.message_done  = done;
      result.messages_sent = counter_in;
   end

   // Read address follows the next frame position, so the byte is registered in time
   always_comb begin
      next_data_pos = sym_in - SYM_W'(PREAMBLE_SYMBOLS);
      rd_addr       = ADDR_W'(next_data_pos[SYM_W-1:1] - 1'b1);
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         crc_ff      <= CRC_SEED;
         sym_ff      <= '0;
         bit_ff      <= '0;
         phase_ff    <= '0;
         active_ff   <= 1'b0;
         line_ff     <= 1'b0;
         counter_ff  <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         crc_ff      <= crc_in;
         sym_ff      <= sym_in;
         bit_ff      <= bit_in;
         phase_ff    <= phase_in;
         active_ff   <= active_in;
         line_ff     <= line_in;
         counter_ff  <= counter_in;
      end
   end

endmodule

`default_nettype wire

@@ src/ook4b6b_frame_transmitter_top.sv @@
// Top level of the OOK 4b6b frame transmitter: engine plus registered response.
// Depends on ook46_pkg, ook46_if and ook46_tx_engine.
`default_nettype none

// Every request transfer (append a byte, send, timer tick) gives exactly one
// response transfer carrying the line level, busy flag, status, frame-done
// pulse and frame count as they stand after that request. Each request is
// handled in the cycle it is taken and its response appears in the next cycle
// from the response register, so one request per cycle is sustained while the
// sink takes each response. Request ready drops only while the response
// register holds a result that the sink has not taken. The CRC is built up
// during transmission, one byte as each count or payload byte goes out.
module ook_4b6b_frame_transmitter_top
   import ook46_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ook46_req_if.sink   req_chan,
   ook46_rsp_if.source rsp_chan
);

   logic       accept;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   // Request side handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   ook46_tx_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_chan.command),
      .data_byte (req_chan.data_byte),
      .result    (result)
   );

   // Response register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.tx_line       = rsp_ff.tx_line;
   assign rsp_chan.tx_active     = rsp_ff.tx_active;
   assign rsp_chan.status        = rsp_ff.status;
   assign rsp_chan.message_done  = rsp_ff.message_done;
   assign rsp_chan.messages_sent = rsp_ff.messages_sent;

endmodule

`default_nettype wire
